[hdl/trbq_pkg.sv]
// Package for the ready and blocked task queues.
// Holds the item types, command and sequencer codes, and memory request structs.
// Depends on nothing; trbq_ctrl and the top level use it.
`timescale 1ns / 1ps

package trbq_pkg;

  localparam int NUM_TASKS = 15;
  localparam int ID_W      = 4;
  localparam int ST_W      = 3;
  localparam int LINK_AW   = ID_W + 1;
  localparam int ID_SLOTS  = 2 ** ID_W;
  localparam int NT_LAST   = (NUM_TASKS > ID_SLOTS - 1) ? ID_SLOTS - 1 : NUM_TASKS;

  localparam logic [ST_W-1:0] STATE_READY   = 3'd1;
  localparam logic [ST_W-1:0] STATE_BLOCKED = 3'd2;

  localparam logic Q_READY   = 1'b0;
  localparam logic Q_BLOCKED = 1'b1;

  typedef enum logic [2:0] {
    CMD_ADD_READY  = 3'd0,
    CMD_ADD_BLOCK  = 3'd1,
    CMD_RM_READY   = 3'd2,
    CMD_RM_BLOCK   = 3'd3,
    CMD_CHK_BLOCK  = 3'd4,
    CMD_REFILL     = 3'd5
  } cmd_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RM_HEAD,
    S_WALK,
    S_UNLINK,
    S_REFILL,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [2:0]      cmd;
    logic [ID_W-1:0] task_id;
    logic [ST_W-1:0] new_state;
  } cmd_t;

  typedef struct packed {
    logic            found;
    logic            clear_tick;
    logic [ST_W-1:0] task_state_out;
    logic            ready_empty;
    logic            blocked_empty;
  } rsp_t;

  typedef struct packed {
    logic               we;
    logic [LINK_AW-1:0] waddr;
    logic [ID_W-1:0]    wdata;
    logic               re;
    logic [LINK_AW-1:0] raddr;
  } link_req_t;

  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] waddr;
    logic [ST_W-1:0] wdata;
    logic            re;
    logic [ID_W-1:0] raddr;
  } st_req_t;

endpackage

[hdl/trbq_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the queue link store and the task state store; no package dependency.
`timescale 1ns / 1ps

module trbq_ram #(
  parameter int AW = 4,
  parameter int DW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/trbq_ctrl.sv]
// Command sequencer: head/tail registers, membership maps, list walks and refill.
// Drives the link and state memories through request structs from trbq_pkg.
`timescale 1ns / 1ps

module trbq_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  trbq_pkg::cmd_t             cmd,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output trbq_pkg::rsp_t             rsp,
  output trbq_pkg::link_req_t        link_req,
  input  logic [trbq_pkg::ID_W-1:0]  link_rdata,
  output trbq_pkg::st_req_t          st_req,
  input  logic [trbq_pkg::ST_W-1:0]  st_rdata
);

  localparam int IW = trbq_pkg::ID_W;
  localparam int SW = trbq_pkg::ST_W;
  localparam int NS = trbq_pkg::ID_SLOTS;

  trbq_pkg::fsm_t state, state_next;

  logic [2:0]            cmd_r, cmd_r_next;
  logic [IW-1:0]         id_r, id_r_next;
  logic [SW-1:0]         ns_r, ns_r_next;
  logic [IW-1:0]         prev, prev_next;
  logic [IW-1:0]         cnt, cnt_next;
  logic [1:0]            ht_vld, ht_vld_next;
  logic [1:0][IW-1:0]    head, head_next;
  logic [1:0][IW-1:0]    tail, tail_next;
  logic [1:0][NS-1:0]    qmap, qmap_next;
  logic [NS-1:0]         st_vld, st_vld_next;
  logic                  st_sv, st_sv_next;
  logic                  res_found, res_found_next;
  logic                  res_clear, res_clear_next;
  logic [SW-1:0]         res_st, res_st_next;
  logic                  out_valid_next;
  trbq_pkg::rsp_t        rsp_next;

  logic          q_sel;
  logic          id_ok;
  logic          member;
  logic          out_free;
  logic [SW-1:0] st_old;

  assign q_sel    = cmd_r[0];
  assign id_ok    = (cmd_r != trbq_pkg::CMD_REFILL) && (id_r != '0) &&
                    (int'(id_r) <= trbq_pkg::NUM_TASKS);
  assign member   = qmap[q_sel][id_r];
  assign out_free = !rsp_valid || rsp_ready;
  assign st_old   = st_sv ? st_rdata : '0;

  assign cmd_ready = (state == trbq_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      trbq_pkg::S_IDLE: begin
        if (cmd_valid) state_next = trbq_pkg::S_EXEC;
      end
      trbq_pkg::S_EXEC: begin
        state_next = trbq_pkg::S_DONE;
        case (cmd_r)
          trbq_pkg::CMD_REFILL: state_next = trbq_pkg::S_REFILL;
          trbq_pkg::CMD_RM_READY, trbq_pkg::CMD_RM_BLOCK: begin
            if (id_ok && member) begin
              if (head[q_sel] != id_r) begin
                state_next = trbq_pkg::S_WALK;
              end else if (head[q_sel] != tail[q_sel]) begin
                state_next = trbq_pkg::S_RM_HEAD;
              end
            end
          end
          default: state_next = trbq_pkg::S_DONE;
        endcase
      end
      trbq_pkg::S_RM_HEAD: state_next = trbq_pkg::S_DONE;
      trbq_pkg::S_WALK: begin
        if (link_rdata == id_r) begin
          state_next = (link_rdata == tail[q_sel]) ? trbq_pkg::S_DONE : trbq_pkg::S_UNLINK;
        end
      end
      trbq_pkg::S_UNLINK: state_next = trbq_pkg::S_DONE;
      trbq_pkg::S_REFILL: begin
        if (cnt == IW'(trbq_pkg::NT_LAST)) state_next = trbq_pkg::S_DONE;
      end
      trbq_pkg::S_DONE: begin
        if (out_free) state_next = trbq_pkg::S_IDLE;
      end
      default: state_next = trbq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_r_next     = cmd_r;
    id_r_next      = id_r;
    ns_r_next      = ns_r;
    prev_next      = prev;
    cnt_next       = cnt;
    ht_vld_next    = ht_vld;
    head_next      = head;
    tail_next      = tail;
    qmap_next      = qmap;
    st_vld_next    = st_vld;
    st_sv_next     = st_sv;
    res_found_next = res_found;
    res_clear_next = res_clear;
    res_st_next    = res_st;
    out_valid_next = rsp_valid && !rsp_ready;
    rsp_next       = rsp;
    link_req       = '0;
    st_req         = '0;
    case (state)
      trbq_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_r_next = cmd.cmd;
          id_r_next  = cmd.task_id;
          ns_r_next  = cmd.new_state;
          cnt_next   = IW'(1);
          st_req.re    = 1'b1;
          st_req.raddr = cmd.task_id;
          st_sv_next   = st_vld[cmd.task_id];
        end
      end
      trbq_pkg::S_EXEC: begin
        res_found_next = 1'b0;
        res_clear_next = 1'b0;
        res_st_next    = id_ok ? st_old : '0;
        if (id_ok) begin
          case (cmd_r)
            trbq_pkg::CMD_ADD_READY, trbq_pkg::CMD_ADD_BLOCK: begin
              res_st_next = (q_sel == trbq_pkg::Q_BLOCKED) ?
                            trbq_pkg::STATE_BLOCKED : trbq_pkg::STATE_READY;
              if (!member) begin
                qmap_next[q_sel][id_r] = 1'b1;
                tail_next[q_sel]       = id_r;
                if (ht_vld[q_sel]) begin
                  link_req.we    = 1'b1;
                  link_req.waddr = {q_sel, tail[q_sel]};
                  link_req.wdata = id_r;
                end else begin
                  ht_vld_next[q_sel] = 1'b1;
                  head_next[q_sel]   = id_r;
                end
              end
            end
            trbq_pkg::CMD_RM_READY, trbq_pkg::CMD_RM_BLOCK: begin
              if (member) begin
                res_found_next = 1'b1;
                res_clear_next = q_sel;
                res_st_next    = ns_r;
                prev_next      = head[q_sel];
                if (head[q_sel] == id_r && head[q_sel] == tail[q_sel]) begin
                  ht_vld_next[q_sel] = 1'b0;
                end else begin
                  link_req.re    = 1'b1;
                  link_req.raddr = {q_sel, head[q_sel]};
                end
              end
            end
            trbq_pkg::CMD_CHK_BLOCK: res_found_next = qmap[trbq_pkg::Q_BLOCKED][id_r];
            default: ;
          endcase
        end
      end
      trbq_pkg::S_RM_HEAD: head_next[q_sel] = link_rdata;
      trbq_pkg::S_WALK: begin
        if (link_rdata == id_r) begin
          if (link_rdata == tail[q_sel]) begin
            tail_next[q_sel] = prev;
          end else begin
            link_req.re    = 1'b1;
            link_req.raddr = {q_sel, link_rdata};
          end
        end else begin
          prev_next      = link_rdata;
          link_req.re    = 1'b1;
          link_req.raddr = {q_sel, link_rdata};
        end
      end
      trbq_pkg::S_UNLINK: begin
        link_req.we    = 1'b1;
        link_req.waddr = {q_sel, prev};
        link_req.wdata = link_rdata;
      end
      trbq_pkg::S_REFILL: begin
        cnt_next = cnt + IW'(1);
        if (!qmap[trbq_pkg::Q_BLOCKED][cnt] && !qmap[trbq_pkg::Q_READY][cnt]) begin
          st_req.we    = 1'b1;
          st_req.waddr = cnt;
          st_req.wdata = trbq_pkg::STATE_READY;
          st_vld_next[cnt] = 1'b1;
          qmap_next[trbq_pkg::Q_READY][cnt] = 1'b1;
          tail_next[trbq_pkg::Q_READY]      = cnt;
          if (ht_vld[trbq_pkg::Q_READY]) begin
            link_req.we    = 1'b1;
            link_req.waddr = {trbq_pkg::Q_READY, tail[trbq_pkg::Q_READY]};
            link_req.wdata = cnt;
          end else begin
            ht_vld_next[trbq_pkg::Q_READY] = 1'b1;
            head_next[trbq_pkg::Q_READY]   = cnt;
          end
        end
      end
      trbq_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_next          = 1'b1;
          rsp_next.found          = res_found;
          rsp_next.clear_tick     = res_clear;
          rsp_next.task_state_out = res_st;
          rsp_next.ready_empty    = !ht_vld[trbq_pkg::Q_READY];
          rsp_next.blocked_empty  = !ht_vld[trbq_pkg::Q_BLOCKED];
          if (id_ok && !cmd_r[2] && (!cmd_r[1] || res_found)) begin
            st_req.we    = 1'b1;
            st_req.waddr = id_r;
            st_req.wdata = res_st;
            st_vld_next[id_r] = 1'b1;
          end
          if (id_ok && cmd_r[2:1] == 2'b01 && res_found) begin
            qmap_next[q_sel][id_r] = 1'b0;
          end
        end
      end
      default: out_valid_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= trbq_pkg::S_IDLE;
      ht_vld    <= '0;
      qmap      <= '0;
      st_vld    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ht_vld    <= ht_vld_next;
      qmap      <= qmap_next;
      st_vld    <= st_vld_next;
      rsp_valid <= out_valid_next;
    end
    cmd_r     <= cmd_r_next;
    id_r      <= id_r_next;
    ns_r      <= ns_r_next;
    prev      <= prev_next;
    cnt       <= cnt_next;
    head      <= head_next;
    tail      <= tail_next;
    st_sv     <= st_sv_next;
    res_found <= res_found_next;
    res_clear <= res_clear_next;
    res_st    <= res_st_next;
    rsp       <= rsp_next;
  end

  a_ready_map: assert property (@(posedge clk) disable iff (rst)
    state == trbq_pkg::S_IDLE |-> ht_vld[0] == (qmap[0] != '0))
    else $error("ready queue valid bit disagrees with its membership map");

  a_block_map: assert property (@(posedge clk) disable iff (rst)
    state == trbq_pkg::S_IDLE |-> ht_vld[1] == (qmap[1] != '0))
    else $error("blocked queue valid bit disagrees with its membership map");

  a_ends_member: assert property (@(posedge clk) disable iff (rst)
    (state == trbq_pkg::S_IDLE && ht_vld[0]) |-> (qmap[0][head[0]] && qmap[0][tail[0]]))
    else $error("ready queue head or tail is not a member");

  a_refill_range: assert property (@(posedge clk) disable iff (rst)
    state == trbq_pkg::S_REFILL |-> (cnt != '0 && int'(cnt) <= trbq_pkg::NT_LAST))
    else $error("refill counter out of range");

endmodule

[hdl/task_ready_blocked_queues.sv]
// Top level of the ready and blocked task queues.
// Instantiates trbq_ctrl and two trbq_ram memories; types come from trbq_pkg.
//
//   channel   direction   payload           handshake
//   cmd       in          trbq_pkg::cmd_t   cmd_valid / cmd_ready
//   rsp       out         trbq_pkg::rsp_t   rsp_valid / rsp_ready
//
// An add, check or invalid command passes through S_EXEC and S_DONE before the next acceptance.
// A removal may add S_RM_HEAD, or S_WALK link reads while walking to the task and S_UNLINK.
// A refill steps one task id a cycle through the state store, ids 1 to min(NUM_TASKS, 15).
// Reset clears the queue valid bits and maps at once; no memory clearing pass is needed.
// A result waits in the output register; it stalls the sequencer only in S_DONE.
`timescale 1ns / 1ps

module task_ready_blocked_queues (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  trbq_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output trbq_pkg::rsp_t rsp
);

  trbq_pkg::link_req_t             link_req;
  trbq_pkg::st_req_t               st_req;
  logic [trbq_pkg::ID_W-1:0]       link_rdata;
  logic [trbq_pkg::ST_W-1:0]       st_rdata;

  trbq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .link_req   (link_req),
    .link_rdata (link_rdata),
    .st_req     (st_req),
    .st_rdata   (st_rdata)
  );

  trbq_ram #(
    .AW (trbq_pkg::LINK_AW),
    .DW (trbq_pkg::ID_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_req.we),
    .waddr (link_req.waddr),
    .wdata (link_req.wdata),
    .re    (link_req.re),
    .raddr (link_req.raddr),
    .rdata (link_rdata)
  );

  trbq_ram #(
    .AW (trbq_pkg::ID_W),
    .DW (trbq_pkg::ST_W)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_req.we),
    .waddr (st_req.waddr),
    .wdata (st_req.wdata),
    .re    (st_req.re),
    .raddr (st_req.raddr),
    .rdata (st_rdata)
  );

endmodule

[tb/task_ready_blocked_queues_test.sv]
// Self-checking test for the ready and blocked task queues (task_ready_blocked_queues).
// Drives commands, predicts each status with its own queue model and checks every item.
// Depends on trbq_pkg and the task_ready_blocked_queues RTL.
`timescale 1ns / 1ps

module task_ready_blocked_queues_test;

  localparam int IW = trbq_pkg::ID_W;
  localparam int SW = trbq_pkg::ST_W;
  localparam int NSLOT = trbq_pkg::ID_SLOTS;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 1050;
  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 200;
  localparam int QUIET_FROM   = 500;
  localparam int QUIET_TO     = 650;
  localparam int DRAIN_CYCLES = trbq_pkg::NUM_TASKS + 9;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  trbq_pkg::cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  trbq_pkg::rsp_t rsp;

  task_ready_blocked_queues dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  // Model of the two linked-list queues, indexed by Q_READY / Q_BLOCKED.
  logic [IW-1:0] q_link [2][NSLOT];
  logic          q_valid [2];
  logic [IW-1:0] q_head [2];
  logic [IW-1:0] q_tail [2];
  logic          blocked_map [NSLOT];
  logic [SW-1:0] state_code [NSLOT];

  trbq_pkg::cmd_t commands_pending [$];
  trbq_pkg::rsp_t status_due [$];

  int  n_items = 0;
  int  n_results = 0;
  int  n_hits = 0;
  int  n_refills = 0;
  int  n_mismatch = 0;
  int  idle_cycles = 0;
  int  cmd_gap = 0;
  int  rsp_gap = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  cmd_sent = 1'b0;

  function automatic bit queue_has(logic which, logic [IW-1:0] id);
    logic [IW-1:0] cur;
    if (!q_valid[which]) return 1'b0;
    cur = q_head[which];
    for (int n = 0; n < NSLOT; n++) begin
      if (cur == id) return 1'b1;
      if (cur == q_tail[which]) return 1'b0;
      cur = q_link[which][cur];
    end
    return 1'b0;
  endfunction

  function automatic void queue_push(logic which, logic [IW-1:0] id);
    if (q_valid[which]) begin
      q_link[which][q_tail[which]] = id;
      q_tail[which] = id;
    end else begin
      q_valid[which] = 1'b1;
      q_head[which] = id;
      q_tail[which] = id;
    end
  endfunction

  function automatic bit queue_unlink(logic which, logic [IW-1:0] id);
    logic [IW-1:0] prev;
    logic [IW-1:0] cur;
    if (!q_valid[which]) return 1'b0;
    if (q_head[which] == id) begin
      if (q_head[which] == q_tail[which]) q_valid[which] = 1'b0;
      else q_head[which] = q_link[which][id];
      return 1'b1;
    end
    prev = q_head[which];
    for (int n = 0; n < NSLOT; n++) begin
      if (prev == q_tail[which]) return 1'b0;
      cur = q_link[which][prev];
      if (cur == id) begin
        if (cur == q_tail[which]) q_tail[which] = prev;
        else q_link[which][prev] = q_link[which][cur];
        return 1'b1;
      end
      prev = cur;
    end
    return 1'b0;
  endfunction

  function automatic trbq_pkg::rsp_t predict_status(trbq_pkg::cmd_t c);
    trbq_pkg::rsp_t r;
    logic [IW-1:0] id;
    bit addressable;
    r = '0;
    id = c.task_id;
    addressable = (id >= 1) && (id <= trbq_pkg::NUM_TASKS);
    if (c.cmd == trbq_pkg::CMD_REFILL) begin
      for (int t = 1; t <= trbq_pkg::NT_LAST; t++) begin
        if (!blocked_map[t] && !queue_has(trbq_pkg::Q_READY, IW'(t))) begin
          state_code[t] = trbq_pkg::STATE_READY;
          queue_push(trbq_pkg::Q_READY, IW'(t));
        end
      end
    end else if (addressable) begin
      case (c.cmd)
        trbq_pkg::CMD_ADD_READY: begin
          state_code[id] = trbq_pkg::STATE_READY;
          if (!queue_has(trbq_pkg::Q_READY, id)) queue_push(trbq_pkg::Q_READY, id);
        end
        trbq_pkg::CMD_ADD_BLOCK: begin
          state_code[id] = trbq_pkg::STATE_BLOCKED;
          if (!blocked_map[id]) begin
            queue_push(trbq_pkg::Q_BLOCKED, id);
            blocked_map[id] = 1'b1;
          end
        end
        trbq_pkg::CMD_RM_READY: begin
          if (queue_unlink(trbq_pkg::Q_READY, id)) begin
            state_code[id] = c.new_state;
            r.found = 1'b1;
          end
        end
        trbq_pkg::CMD_RM_BLOCK: begin
          if (queue_unlink(trbq_pkg::Q_BLOCKED, id)) begin
            state_code[id] = c.new_state;
            blocked_map[id] = 1'b0;
            r.found = 1'b1;
            r.clear_tick = 1'b1;
          end
        end
        trbq_pkg::CMD_CHK_BLOCK: r.found = queue_has(trbq_pkg::Q_BLOCKED, id);
        default: ;
      endcase
      r.task_state_out = state_code[id];
    end
    r.ready_empty = !q_valid[trbq_pkg::Q_READY];
    r.blocked_empty = !q_valid[trbq_pkg::Q_BLOCKED];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (n_items >= QUIET_FROM && n_items < QUIET_TO) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_command(logic [2:0] code, logic [IW-1:0] id,
                             logic [SW-1:0] ns);
    trbq_pkg::cmd_t c;
    c.cmd = code;
    c.task_id = id;
    c.new_state = ns;
    commands_pending.push_back(c);
  endtask

  // Command side: accept bookkeeping on the rising edge, driving on the falling edge.
  always @(posedge clk) begin
    if (!rst && cmd_valid && cmd_ready) begin
      status_due.push_back(predict_status(cmd));
      n_items++;
      if (cmd.cmd == trbq_pkg::CMD_REFILL) n_refills++;
      cmd_sent = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_sent) begin
      if (cmd_valid) cmd_gap = pick_gap();
      if (cmd_gap > 0) begin
        cmd_gap--;
        cmd_valid <= 1'b0;
      end else if (commands_pending.size() > 0) begin
        cmd <= commands_pending.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
    cmd_sent = 1'b0;
  end

  // Status side: one long hold-off so the block backs up, random stalls otherwise.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (!hold_done && n_results >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      rsp_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    trbq_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      n_results++;
      if (status_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("Unexpected status item: found=%0b clear=%0b state=%0d re=%0b be=%0b",
                   rsp.found, rsp.clear_tick, rsp.task_state_out,
                   rsp.ready_empty, rsp.blocked_empty);
      end else begin
        want = status_due.pop_front();
        if (want.found) n_hits++;
        if (rsp.found !== want.found || rsp.clear_tick !== want.clear_tick ||
            rsp.task_state_out !== want.task_state_out ||
            rsp.ready_empty !== want.ready_empty ||
            rsp.blocked_empty !== want.blocked_empty) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("Status %0d mismatch: expected found=%0b clear=%0b state=%0d re=%0b be=%0b,",
                     n_results, want.found, want.clear_tick, want.task_state_out,
                     want.ready_empty, want.blocked_empty);
            $display("  got found=%0b clear=%0b state=%0d re=%0b be=%0b",
                     rsp.found, rsp.clear_tick, rsp.task_state_out,
                     rsp.ready_empty, rsp.blocked_empty);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without a handshake.", idle_cycles);
        $display("task_ready_blocked_queues_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int sel;
    int id_hi;
    logic [2:0] code;
    logic [IW-1:0] id;
    for (int i = 0; i < NSLOT; i++) begin
      q_link[trbq_pkg::Q_READY][i] = '0;
      q_link[trbq_pkg::Q_BLOCKED][i] = '0;
      blocked_map[i] = 1'b0;
      state_code[i] = '0;
    end
    q_valid[trbq_pkg::Q_READY] = 1'b0;
    q_valid[trbq_pkg::Q_BLOCKED] = 1'b0;
    q_head[trbq_pkg::Q_READY] = '0;
    q_head[trbq_pkg::Q_BLOCKED] = '0;
    q_tail[trbq_pkg::Q_READY] = '0;
    q_tail[trbq_pkg::Q_BLOCKED] = '0;

    // Directed part: empty queues, duplicates, head, middle and tail removal,
    // misses, invalid ids, spare command codes and refill around blocked tasks.
    add_command(trbq_pkg::CMD_CHK_BLOCK, 4'd3, 3'd0);
    add_command(trbq_pkg::CMD_RM_READY, 4'd3, 3'd7);
    add_command(trbq_pkg::CMD_ADD_READY, 4'd1, 3'd0);
    add_command(trbq_pkg::CMD_ADD_READY, 4'd2, 3'd0);
    add_command(trbq_pkg::CMD_ADD_READY, 4'd3, 3'd0);
    add_command(trbq_pkg::CMD_ADD_READY, 4'd2, 3'd0);
    add_command(trbq_pkg::CMD_ADD_BLOCK, 4'd4, 3'd0);
    add_command(trbq_pkg::CMD_ADD_BLOCK, 4'd5, 3'd0);
    add_command(trbq_pkg::CMD_ADD_BLOCK, 4'd6, 3'd0);
    add_command(trbq_pkg::CMD_RM_READY, 4'd2, 3'd7);
    add_command(trbq_pkg::CMD_RM_READY, 4'd1, 3'd0);
    add_command(trbq_pkg::CMD_RM_READY, 4'd3, 3'd5);
    add_command(trbq_pkg::CMD_CHK_BLOCK, 4'd5, 3'd0);
    add_command(trbq_pkg::CMD_CHK_BLOCK, 4'd6, 3'd0);
    add_command(trbq_pkg::CMD_CHK_BLOCK, 4'd1, 3'd0);
    add_command(trbq_pkg::CMD_RM_BLOCK, 4'd6, 3'd7);
    add_command(trbq_pkg::CMD_RM_BLOCK, 4'd4, 3'd0);
    add_command(trbq_pkg::CMD_RM_BLOCK, 4'd9, 3'd3);
    add_command(trbq_pkg::CMD_ADD_BLOCK, 4'd15, 3'd7);
    add_command(trbq_pkg::CMD_ADD_READY, 4'd0, 3'd7);
    add_command(trbq_pkg::CMD_ADD_BLOCK, 4'd0, 3'd0);
    add_command(CMD_SPARE_LO, 4'd15, 3'd7);
    add_command(CMD_SPARE_HI, 4'd5, 3'd0);
    add_command(trbq_pkg::CMD_REFILL, 4'd0, 3'd0);
    add_command(trbq_pkg::CMD_RM_READY, 4'd15, 3'd7);
    add_command(trbq_pkg::CMD_RM_BLOCK, 4'd15, 3'd3);
    add_command(trbq_pkg::CMD_REFILL, 4'd15, 3'd7);
    add_command(trbq_pkg::CMD_RM_READY, 4'd8, 3'd7);

    // Random part: phases alternate between a few ids, which makes repeats and
    // hits common, and the full id range.
    id_hi = 4;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) id_hi = (id_hi == 4) ? trbq_pkg::NUM_TASKS : 4;
      sel = $urandom_range(0, 99);
      id = IW'($urandom_range(1, id_hi));
      if (sel < 3) begin
        code = 3'($urandom_range(0, 4));
        id = '0;
      end else if (sel < 6) begin
        code = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        id = IW'($urandom_range(0, NSLOT - 1));
      end else if (sel < 26) code = trbq_pkg::CMD_ADD_READY;
      else if (sel < 46) code = trbq_pkg::CMD_ADD_BLOCK;
      else if (sel < 66) code = trbq_pkg::CMD_RM_READY;
      else if (sel < 84) code = trbq_pkg::CMD_RM_BLOCK;
      else if (sel < 95) code = trbq_pkg::CMD_CHK_BLOCK;
      else code = trbq_pkg::CMD_REFILL;
      add_command(code, id, SW'($urandom_range(0, 7)));
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (commands_pending.size() != 0 || cmd_valid || status_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands (%0d refills) and checked %0d status items, %0d with found set,",
             n_items, n_refills, n_results, n_hits);
    $display("including a %0d-cycle output hold-off; %0d mismatches.", HOLD_CYCLES, n_mismatch);
    if (n_mismatch == 0 && status_due.size() == 0) begin
      $display("task_ready_blocked_queues_test OK");
    end else begin
      $display("task_ready_blocked_queues_test NOT OK");
    end
    $finish;
  end

endmodule
